// ===== hw/rtl/prsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package prsc_pkg;
  localparam logic [2:0] OP_SET_CART = 3'd0;
  localparam logic [2:0] OP_SET_POLAR = 3'd1;
  localparam logic [2:0] OP_MOVE = 3'd2;
  localparam logic [2:0] OP_ROTATE = 3'd3;
  localparam logic [2:0] OP_RESIZE = 3'd4;

  localparam int GuardBits = 8;
  localparam int CordW = 42;
  localparam logic signed [31:0] GainQ30 = 32'sd652032874;
  localparam logic signed [31:0] PiQ29 = 32'sd1686629711;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0: t = 32'd536870912; 5'd1: t = 32'd316933406; 5'd2: t = 32'd167458907;
      5'd3: t = 32'd85004756; 5'd4: t = 32'd42667331; 5'd5: t = 32'd21354465;
      5'd6: t = 32'd10679838; 5'd7: t = 32'd5340245; 5'd8: t = 32'd2670163;
      5'd9: t = 32'd1335087; 5'd10: t = 32'd667544; 5'd11: t = 32'd333772;
      5'd12: t = 32'd166886; 5'd13: t = 32'd83443; 5'd14: t = 32'd41722;
      5'd15: t = 32'd20861; 5'd16: t = 32'd10430; 5'd17: t = 32'd5215;
      5'd18: t = 32'd2608; 5'd19: t = 32'd1304; 5'd20: t = 32'd652;
      5'd21: t = 32'd326; 5'd22: t = 32'd163; 5'd23: t = 32'd81;
      5'd24: t = 32'd41; 5'd25: t = 32'd20; 5'd26: t = 32'd10;
      5'd27: t = 32'd5; 5'd28: t = 32'd3; 5'd29: t = 32'd1;
      5'd30: t = 32'd1; default: t = 32'd0;
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    if (v > 96'sd2147483647) return 32'sh7fffffff;
    if (v < -96'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/prsc_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one micro-rotation per cycle; vec selects vectoring mode
module prsc_cordic
  import prsc_pkg::*;
#(
  parameter int Steps = 24
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  input  wire                     vec,
  input  wire signed [CordW-1:0]  x0,
  input  wire signed [CordW-1:0]  y0,
  input  wire signed [32:0]       z0,
  output logic                    done,
  output logic signed [CordW-1:0] xo,
  output logic signed [CordW-1:0] yo,
  output logic signed [32:0]      zo
);
  logic busy_r;
  logic [4:0] i_r;
  logic signed [CordW-1:0] dx, dy;
  logic dir;
  logic [31:0] at;
  always_comb begin
    dx = xo >>> i_r;
    dy = yo >>> i_r;
    dir = vec ? ~yo[CordW-1] : ~zo[32];
    at = atan_turn(i_r);
  end
  always_ff @(posedge clk) begin
    done <= rst_n && !start && busy_r && (i_r == 5'(Steps - 1));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r <= '0;
      xo <= x0;
      yo <= y0;
      zo <= z0;
    end else if (busy_r) begin
      if (dir ^ vec) begin
        xo <= xo - dy;
        yo <= yo + dx;
      end else begin
        xo <= xo + dy;
        yo <= yo - dx;
      end
      zo <= (dir ^ vec) ? zo - $signed({1'b0, at}) : zo + $signed({1'b0, at});
      i_r <= i_r + 5'd1;
      if (i_r == 5'(Steps - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/point_rotate_scale_convert.sv =====
`timescale 1ns / 1ps
`default_nettype none
// x,y view results of set/move/resize/read pass the resolve and output states;
// rotate or set polar add 4 digit steps for the degree conversion, the cordic
// and the gain correction; a polar view adds a vectoring pass, or only the angle
// state for a point on the x axis. One item at a time, the next accepted once
// the result is taken. A single shared cordic unit, one micro-rotation per cycle.
// synchronous active-low reset clears the point to the origin
module point_rotate_scale_convert
  import prsc_pkg::*;
#(
  parameter int CORDIC_STEPS = 24,
  parameter int FRACTION_BITS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire        [2:0]  in_op,
  input  wire signed [31:0] in_a_value,
  input  wire signed [31:0] in_b_value,
  input  wire               in_polar_view,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [31:0] out_first_value,
  output logic signed [31:0] out_second_value
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEG = 4'd1, S_ROT = 4'd2, S_G1 = 4'd3,
    S_G2 = 4'd4, S_VEC0 = 4'd5, S_VEC = 4'd6, S_VG = 4'd7, S_ANG = 4'd8,
    S_OUT = 4'd9, S_DONE = 4'd10, S_RES = 4'd11, S_DIV = 4'd12;
  // offset keeps the dividend positive and is a multiple of 2^32 turns
  localparam logic signed [63:0] DegBias = (64'sd45 <<< (60 - FRACTION_BITS)) + 64'sd22;
  localparam logic [44:0] RecipQ28 = 45'd5965233;
  localparam logic signed [CordW-1:0] GuardHalf = CordW'(1) <<< (GuardBits - 1);

  logic [3:0] st_r;
  logic signed [31:0] px_r, py_r, a_r, b_r;
  logic [2:0] op_r;
  logic pv_r;
  logic [63:0] u_r;
  logic [5:0] rem_r;
  logic [31:0] q_r;
  logic [1:0] k_r;
  logic signed [31:0] dg;
  logic [63:0] du;
  logic [21:0] dv;
  logic [44:0] dprod;
  logic [15:0] dq;
  logic [5:0] drem;
  logic signed [CordW-1:0] cx0, cy0;
  logic signed [32:0] cz0;
  logic cstart, cvec, cdone;
  logic signed [CordW-1:0] cxo, cyo;
  logic signed [32:0] czo;
  logic gsel_r;
  logic signed [63:0] tg;
  logic signed [95:0] prod;
  logic signed [31:0] gx_r;

  prsc_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cstart), .vec(cvec), .x0(cx0), .y0(cy0), .z0(cz0),
    .done(cdone), .xo(cxo), .yo(cyo), .zo(czo));

  assign in_stall = (st_r != S_IDLE);

  always_comb begin
    tg = 64'((cxo + GuardHalf) >>> GuardBits);
    if (gsel_r) tg = 64'((cyo + GuardHalf) >>> GuardBits);
    prod = (96'(tg) * 96'(GainQ30) + (96'sd1 <<< 29)) >>> 30;
    // turn = floor((deg * 2^(32-frac) + 180) / 360), taken as floor(m / 45)
    dg = (op_r == OP_SET_POLAR) ? b_r : a_r;
    du = (64'(dg) <<< (29 - FRACTION_BITS)) + DegBias;
    // long division by 45 in 16-bit digits, each by reciprocal multiply
    dv = {rem_r, u_r[63:48]};
    dprod = 45'(dv) * RecipQ28;
    dq = dprod[43:28];
    drem = 6'(dv - 22'(dq) * 22'd45);
  end

  always_ff @(posedge clk) begin
    cstart <= rst_n && (st_r == S_DEG || st_r == S_VEC0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      px_r <= '0;
      py_r <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_op; a_r <= in_a_value; b_r <= in_b_value;
          pv_r <= in_polar_view; st_r <= S_RES;
        end
        S_RES: begin
          if (op_r == OP_SET_POLAR || op_r == OP_ROTATE) begin
            u_r <= du; rem_r <= '0; q_r <= '0; k_r <= '0; st_r <= S_DIV;
          end else st_r <= S_OUT;
          if (op_r == OP_SET_CART) begin
            px_r <= a_r; py_r <= b_r;
          end else if (op_r == OP_MOVE) begin
            px_r <= sat32(96'(px_r) + 96'(a_r));
            py_r <= sat32(96'(py_r) + 96'(b_r));
          end else if (op_r == OP_RESIZE) begin
            px_r <= sat32((96'(px_r) * 96'(a_r) + (96'sd1 <<< (FRACTION_BITS - 1)))
              >>> FRACTION_BITS);
            py_r <= sat32((96'(py_r) * 96'(a_r) + (96'sd1 <<< (FRACTION_BITS - 1)))
              >>> FRACTION_BITS);
          end
        end
        S_DIV: begin
          u_r <= {u_r[47:0], 16'd0}; rem_r <= drem; q_r <= {q_r[15:0], dq};
          k_r <= k_r + 2'd1;
          if (k_r == 2'd3) st_r <= S_DEG;
        end
        S_DEG: begin
          logic [31:0] th;
          logic signed [CordW-1:0] sx, sy;
          th = q_r;
          sx = (op_r == OP_SET_POLAR) ? CordW'(a_r) <<< GuardBits
            : CordW'(px_r) <<< GuardBits;
          sy = (op_r == OP_SET_POLAR) ? '0 : CordW'(py_r) <<< GuardBits;
          if (th[31:30] == 2'd1 || th[31:30] == 2'd2) begin
            sx = -sx; sy = -sy; th = th + 32'h80000000;
          end
          cx0 <= sx; cy0 <= sy; cz0 <= 33'($signed(th));
          cvec <= 1'b0; st_r <= S_ROT;
        end
        S_ROT: if (cdone) begin gsel_r <= 1'b0; st_r <= S_G1; end
        S_G1: begin gx_r <= sat32(prod); gsel_r <= 1'b1; st_r <= S_G2; end
        S_G2: begin px_r <= gx_r; py_r <= sat32(prod); st_r <= S_OUT; end
        S_OUT: begin
          if (!pv_r) begin
            out_first_value <= px_r; out_second_value <= py_r;
            out_valid <= 1'b1; st_r <= S_DONE;
          end else if (py_r == 0) begin
            out_first_value <= sat32(96'(px_r[31] ? -64'(px_r) : 64'(px_r)));
            cz0 <= px_r[31] ? 33'sh080000000 : '0;
            st_r <= S_ANG;
          end else st_r <= S_VEC0;
        end
        S_VEC0: begin
          logic signed [CordW-1:0] sx, sy;
          sx = CordW'(px_r) <<< GuardBits; sy = CordW'(py_r) <<< GuardBits;
          cz0 <= (sx < 0) ? 33'sh080000000 : '0;
          if (sx < 0) begin sx = -sx; sy = -sy; end
          cx0 <= sx; cy0 <= sy; cvec <= 1'b1; gsel_r <= 1'b0;
          st_r <= S_VEC;
        end
        S_VEC: if (cdone) st_r <= S_VG;
        S_VG: begin
          out_first_value <= sat32(prod);
          cz0 <= (czo[31:0] == 32'h80000000) ? 33'sh080000000
            : 33'($signed(czo[31:0]));
          st_r <= S_ANG;
        end
        S_ANG: begin
          out_second_value <= sat32((96'(cz0) * 96'(PiQ29)
            + (96'sd1 <<< (59 - FRACTION_BITS))) >>> (60 - FRACTION_BITS));
          out_valid <= 1'b1; st_r <= S_DONE;
        end
        S_DONE: if (!out_stall) begin out_valid <= 1'b0; st_r <= S_IDLE; end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result while idle");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_first_value))
    else $error("result dropped");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("accept not taken");
endmodule
`default_nettype wire

// ===== tb/sv/tb_point_rotate_scale_convert.sv =====
`timescale 1ns / 1ps
module tb_point_rotate_scale_convert;
  import prsc_pkg::*;

  localparam int STEPS = 24;
  localparam int FRAC = 16;
  localparam logic [2:0] OP_READ = 3'd5;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam longint GAIN = 652032874;
  localparam longint PI29 = 1686629711;
  localparam longint HALF_TURN = 64'sh80000000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT = 1500000;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;
  localparam logic signed [31:0] PI_Q16 = 32'sd205887;

  localparam longint ARCTAN [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  typedef struct packed {
    logic signed [31:0] first_v;
    logic signed [31:0] second_v;
  } point_out_t;

  typedef struct {
    logic [2:0] op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic polar;
    bit fixed;
    point_out_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_op;
  logic signed [31:0] in_a_value;
  logic signed [31:0] in_b_value;
  logic in_polar_view;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_first_value;
  logic signed [31:0] out_second_value;

  point_rotate_scale_convert DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_a_value(in_a_value), .in_b_value(in_b_value),
    .in_polar_view(in_polar_view),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first_value(out_first_value), .out_second_value(out_second_value)
  );

  // model copy of the stored point
  logic signed [31:0] pt_x, pt_y;
  point_out_t pending_points[$];
  stim_row_t directed_rows[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cycles = 0;
  bit idle_on = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int stall_left = 0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > longint'(MAXV)) return MAXV;
    if (v < longint'(MINV)) return MINV;
    return v[31:0];
  endfunction

  function automatic longint shift_round(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] deg_to_bam(longint deg);
    longint m, r, hi, rem, lo;
    m = longint'(360) <<< FRAC;
    r = deg % m;
    if (r < 0) r += m;
    hi = (r <<< 16) / m;
    rem = (r <<< 16) % m;
    lo = ((rem <<< 16) + m / 2) / m;
    return 32'(hi * 65536 + lo);
  endfunction

  function automatic logic signed [31:0] unscale(longint v);
    return clamp32(shift_round(shift_round(v, GuardBits) * GAIN, 30));
  endfunction

  function automatic void turn_point(input longint x, input longint y,
                                     input logic [31:0] theta,
                                     output logic signed [31:0] ox,
                                     output logic signed [31:0] oy);
    longint cx, cy, z, dx, dy;
    cx = x <<< GuardBits;
    cy = y <<< GuardBits;
    if (theta[31:30] == 2'd1 || theta[31:30] == 2'd2) begin
      cx = -cx;
      cy = -cy;
      theta = theta + 32'h80000000;
    end
    z = longint'($signed(theta));
    for (int i = 0; i < STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= ARCTAN[i];
      end else begin
        cx += dx; cy -= dy; z += ARCTAN[i];
      end
    end
    ox = unscale(cx);
    oy = unscale(cy);
  endfunction

  function automatic point_out_t to_polar(longint x, longint y);
    longint cx, cy, st, dx, dy;
    logic [31:0] z;
    point_out_t r;
    z = '0;
    if (y == 0) begin
      r.first_v = clamp32(x < 0 ? -x : x);
      st = (x < 0) ? HALF_TURN : 0;
    end else begin
      cx = x <<< GuardBits;
      cy = y <<< GuardBits;
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        z = 32'h80000000;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx; cy -= dy; z = z + 32'(ARCTAN[i]);
        end else begin
          cx -= dx; cy += dy; z = z - 32'(ARCTAN[i]);
        end
      end
      r.first_v = unscale(cx);
      st = longint'($signed(z));
      // half a turn is reported as +pi
      if (st == -HALF_TURN) st = HALF_TURN;
    end
    r.second_v = clamp32(shift_round(st * PI29, 60 - FRAC));
    return r;
  endfunction

  function automatic point_out_t apply_op(logic [2:0] op, logic signed [31:0] a,
                                          logic signed [31:0] b, logic polar);
    point_out_t r;
    case (op)
      OP_SET_CART: begin
        pt_x = a;
        pt_y = b;
      end
      OP_SET_POLAR: turn_point(longint'(a), 0, deg_to_bam(longint'(b)), pt_x, pt_y);
      OP_MOVE: begin
        pt_x = clamp32(longint'(pt_x) + longint'(a));
        pt_y = clamp32(longint'(pt_y) + longint'(b));
      end
      OP_ROTATE: turn_point(longint'(pt_x), longint'(pt_y), deg_to_bam(longint'(a)),
                            pt_x, pt_y);
      OP_RESIZE: begin
        pt_x = clamp32(shift_round(longint'(pt_x) * longint'(a), FRAC));
        pt_y = clamp32(shift_round(longint'(pt_y) * longint'(a), FRAC));
      end
      default: ;
    endcase
    if (polar) r = to_polar(longint'(pt_x), longint'(pt_y));
    else r = '{pt_x, pt_y};
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results waiting", cycles,
               pending_points.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts plus one long hold on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      stall_left = 300;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker, sampled mid-cycle so the values are settled
  always @(negedge clk) begin
    point_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: %h %h", out_first_value, out_second_value);
      end else begin
        want = pending_points.pop_front();
        if (out_first_value !== want.first_v || out_second_value !== want.second_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected %h %h, got %h %h", results_seen,
                     want.first_v, want.second_v, out_first_value, out_second_value);
        end
      end
    end
  end

  task automatic send_item(input logic [2:0] op, input logic signed [31:0] a,
                           input logic signed [31:0] b, input logic polar,
                           input bit fixed, input point_out_t want);
    point_out_t got;
    bit taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_a_value <= a;
    in_b_value <= b;
    in_polar_view <= polar;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    got = apply_op(op, a, b, polar);
    pending_points.push_back(fixed ? want : got);
    items_sent++;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? MAXV : MINV;
      2: return 32'($signed($urandom_range(0, 200)) - 100);
      default: return 32'($signed($urandom_range(0, 400 * 65536)) - 200 * 65536);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_degrees();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8)) * 45 * 65536 - 180 * 65536);
      default: return 32'($signed($urandom_range(0, 1440 * 65536)) - 720 * 65536);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_factor();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return ONE;
      default: return 32'($signed($urandom_range(0, 3 * 65536)) - 3 * 32768);
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    logic signed [31:0] a, b;
    point_out_t none;
    none = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_READ;
    in_a_value <= '0;
    in_b_value <= '0;
    in_polar_view <= 1'b0;
    pt_x = '0;
    pt_y = '0;

    directed_rows.push_back('{OP_READ, 0, 0, 0, 1, '{0, 0}});
    directed_rows.push_back('{OP_READ, MAXV, MINV, 1, 1, '{0, 0}});
    directed_rows.push_back('{OP_SET_CART, MAXV, MINV, 0, 1, '{MAXV, MINV}});
    directed_rows.push_back('{OP_SET_CART, MINV, MAXV, 0, 1, '{MINV, MAXV}});
    directed_rows.push_back('{OP_MOVE, MINV, MAXV, 0, 1, '{MINV, MAXV}});
    directed_rows.push_back('{OP_SET_CART, MINV, 0, 1, 1, '{MAXV, PI_Q16}});
    directed_rows.push_back('{OP_SET_CART, 0, 0, 1, 1, '{0, 0}});
    directed_rows.push_back('{OP_SET_CART, 5 * ONE, 0, 1, 1, '{5 * ONE, 0}});
    directed_rows.push_back('{OP_SET_CART, -5 * ONE, 0, 1, 0, none});
    directed_rows.push_back('{OP_SET_CART, -5 * ONE, -1, 1, 0, none});
    directed_rows.push_back('{OP_SET_CART, 3 * ONE, 4 * ONE, 1, 0, none});
    directed_rows.push_back('{OP_SET_POLAR, 10 * ONE, 90 * ONE, 0, 0, none});
    directed_rows.push_back('{OP_SET_POLAR, -10 * ONE, MINV, 1, 0, none});
    directed_rows.push_back('{OP_SET_POLAR, MAXV, MAXV, 0, 0, none});
    directed_rows.push_back('{OP_ROTATE, 180 * ONE, MAXV, 1, 0, none});
    directed_rows.push_back('{OP_ROTATE, -360 * ONE, 0, 0, 0, none});
    directed_rows.push_back('{OP_ROTATE, MINV, 0, 0, 0, none});
    directed_rows.push_back('{OP_RESIZE, -ONE, 0, 0, 0, none});
    directed_rows.push_back('{OP_RESIZE, MAXV, 0, 0, 0, none});
    directed_rows.push_back('{OP_RESIZE, MINV, 0, 1, 0, none});
    directed_rows.push_back('{OP_MOVE, MAXV, MAXV, 0, 0, none});
    directed_rows.push_back('{OP_SPARE_LO, ONE, ONE, 0, 0, none});
    directed_rows.push_back('{OP_SPARE_HI, ONE, ONE, 1, 0, none});
    directed_rows.push_back('{OP_RESIZE, 0, 0, 1, 1, '{0, 0}});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].polar, directed_rows[i].fixed, directed_rows[i].want);

    idle_on = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) hold_req = 1'b1;
      if (n == RANDOM_ITEMS - 300) idle_on = 1'b0;
      op = 3'($urandom_range(0, 7));
      // keep the point in a useful range now and then
      if ($urandom_range(0, 9) == 0) op = OP_SET_CART;
      case (op)
        OP_SET_POLAR: begin a = rand_coord(); b = rand_degrees(); end
        OP_ROTATE: begin a = rand_degrees(); b = $urandom(); end
        OP_RESIZE: begin a = rand_factor(); b = $urandom(); end
        default: begin
          a = rand_coord();
          b = ($urandom_range(0, 7) == 0) ? 32'sd0 : rand_coord();
        end
      endcase
      send_item(op, a, b, 1'($urandom()), 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("sent %0d items over all op codes, %0d results checked in both views",
             items_sent, results_seen);
    $display("with saturation extremes, axis points, stall bursts and a long output hold");
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
